@@ src/cfws_pkg.sv @@
// Shared constants and codes for the circular FIFO with search.
package cfws_pkg;

   localparam int DEPTH  = 64;
   localparam int SLOT_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;
   localparam int KIND_W = 3;
   localparam int STAT_W = 2;

   localparam logic [KIND_W-1:0] OP_ENQ    = 3'd0;
   localparam logic [KIND_W-1:0] OP_DEQ    = 3'd1;
   localparam logic [KIND_W-1:0] OP_PEEK   = 3'd2;
   localparam logic [KIND_W-1:0] OP_SEARCH = 3'd3;
   localparam logic [KIND_W-1:0] OP_CLEAR  = 3'd4;

   localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
   localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;
   localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd3;

endpackage

@@ src/cfws_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module cfws_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/circular_fifo_with_search_unit.sv @@
// Top level: ring-buffer FIFO of signed words with a linear key search.
//
// Usage:
//  - Commands enter on start with req_kind and req_value; a command is taken
//    at a clock edge where start is high and busy is low.
//  - Each command yields one transaction on the rsp_ ports, marked by
//    rsp_valid for exactly one cycle; the receiver cannot hold it off.
//  - Enqueue, dequeue, peek, clear, unused kinds and a search of an empty
//    queue: result in the cycle after acceptance, busy stays low, so one
//    command per cycle is sustained.
//  - Search: the ring memory has one read port, so the scan reads one entry
//    per cycle from the oldest. Busy stays high while the scan runs; the first
//    match (counted from the oldest) or a miss after the newest entry ends the
//    scan, and the registered result follows.
//  - csr_we/csr_wdata set the capacity (0 acts as 1, above 64 acts as 64)
//    and empty the queue; write only while idle.
//  - Reset (synchronous, active high) empties the queue and sets the
//    capacity to 64; ring contents are not cleared and need no clearing pass.
module circular_fifo_with_search_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [cfws_pkg::KIND_W-1:0]        req_kind,
   input  logic signed [cfws_pkg::DATA_W-1:0] req_value,
   input  logic                               csr_we,
   input  logic [cfws_pkg::CNT_W-1:0]         csr_wdata,
   output logic                               rsp_valid,
   output logic [cfws_pkg::STAT_W-1:0]        rsp_status,
   output logic signed [cfws_pkg::DATA_W-1:0] rsp_data,
   output logic [cfws_pkg::SLOT_W-1:0]        rsp_slot,
   output logic [cfws_pkg::CNT_W-1:0]         rsp_count,
   output logic                               rsp_empty_res,
   output logic                               rsp_full_res
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   function automatic logic [cfws_pkg::SLOT_W-1:0] advance(
      input logic [cfws_pkg::SLOT_W-1:0] s,
      input logic [cfws_pkg::CNT_W-1:0]  cap
   );
      logic [cfws_pkg::CNT_W-1:0] nxt;
      nxt = {{(cfws_pkg::CNT_W - cfws_pkg::SLOT_W){1'b0}}, s} + cfws_pkg::CNT_W'(1);
      return (nxt >= cap) ? '0 : nxt[cfws_pkg::SLOT_W-1:0];
   endfunction

   logic                                state_ff, state_in;
   logic [cfws_pkg::CNT_W-1:0]          cap_ff, cap_in;
   logic [cfws_pkg::SLOT_W-1:0]         head_ff, head_in;
   logic [cfws_pkg::SLOT_W-1:0]         tail_ff, tail_in;
   logic [cfws_pkg::CNT_W-1:0]          count_ff, count_in;
   logic signed [cfws_pkg::DATA_W-1:0]  key_ff, key_in;
   logic [cfws_pkg::SLOT_W-1:0]         cmp_slot_ff, cmp_slot_in;
   logic [cfws_pkg::SLOT_W-1:0]         scan_addr_ff, scan_addr_in;
   logic [cfws_pkg::CNT_W-1:0]          remain_ff, remain_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                rd_sel_ff, rd_sel_in;
   logic [cfws_pkg::STAT_W-1:0]         stat_ff, stat_in;
   logic [cfws_pkg::SLOT_W-1:0]         slot_ff, slot_in;
   logic [cfws_pkg::CNT_W-1:0]          rcount_ff, rcount_in;
   logic                                empty_ff, empty_in;
   logic                                full_ff, full_in;
   logic [cfws_pkg::CNT_W-1:0]          csr_cap;

   logic                                ram_we;
   logic [cfws_pkg::SLOT_W-1:0]         ram_rd_addr;
   logic signed [cfws_pkg::DATA_W-1:0]  ram_rdata;

   cfws_ram #(
      .WIDTH (cfws_pkg::DATA_W),
      .DEPTH (cfws_pkg::DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (tail_ff),
      .wr_data (req_value),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      if (csr_wdata == '0) begin
         csr_cap = cfws_pkg::CNT_W'(1);
      end else if (csr_wdata > cfws_pkg::CNT_W'(cfws_pkg::DEPTH)) begin
         csr_cap = cfws_pkg::CNT_W'(cfws_pkg::DEPTH);
      end else begin
         csr_cap = csr_wdata;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cap_in       = cap_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      key_in       = key_ff;
      cmp_slot_in  = cmp_slot_ff;
      scan_addr_in = scan_addr_ff;
      remain_in    = remain_ff;
      rsp_valid_in = 1'b0;
      rd_sel_in    = 1'b0;
      stat_in      = stat_ff;
      slot_in      = slot_ff;
      ram_we       = 1'b0;
      // idle reads always target the oldest entry for dequeue, peek and search
      ram_rd_addr  = (state_ff == ST_SCAN) ? scan_addr_ff : head_ff;

      if (csr_we) begin
         cap_in   = csr_cap;
         head_in  = '0;
         tail_in  = '0;
         count_in = '0;
      end else if (state_ff == ST_IDLE) begin
         if (start) begin
            rsp_valid_in = 1'b1;
            stat_in      = cfws_pkg::STAT_OK;
            slot_in      = '0;
            case (req_kind)
               cfws_pkg::OP_ENQ: begin
                  if (count_ff >= cap_ff) begin
                     stat_in = cfws_pkg::STAT_FULL;
                  end else begin
                     ram_we   = 1'b1;
                     tail_in  = advance(tail_ff, cap_ff);
                     count_in = count_ff + cfws_pkg::CNT_W'(1);
                  end
               end
               cfws_pkg::OP_DEQ, cfws_pkg::OP_PEEK: begin
                  if (count_ff == '0) begin
                     stat_in = cfws_pkg::STAT_EMPTY;
                  end else begin
                     rd_sel_in = 1'b1;
                     if (req_kind == cfws_pkg::OP_DEQ) begin
                        head_in  = advance(head_ff, cap_ff);
                        count_in = count_ff - cfws_pkg::CNT_W'(1);
                     end
                  end
               end
               cfws_pkg::OP_SEARCH: begin
                  if (count_ff == '0) begin
                     stat_in = cfws_pkg::STAT_NOTFOUND;
                  end else begin
                     // oldest entry is read this cycle; compare it next cycle
                     rsp_valid_in = 1'b0;
                     state_in     = ST_SCAN;
                     key_in       = req_value;
                     cmp_slot_in  = head_ff;
                     scan_addr_in = advance(head_ff, cap_ff);
                     remain_in    = count_ff - cfws_pkg::CNT_W'(1);
                  end
               end
               cfws_pkg::OP_CLEAR: begin
                  head_in  = '0;
                  tail_in  = '0;
                  count_in = '0;
               end
               default: begin
               end
            endcase
         end
      end else begin
         if (ram_rdata == key_ff) begin
            rsp_valid_in = 1'b1;
            stat_in      = cfws_pkg::STAT_OK;
            slot_in      = cmp_slot_ff;
            state_in     = ST_IDLE;
         end else if (remain_ff == '0) begin
            rsp_valid_in = 1'b1;
            stat_in      = cfws_pkg::STAT_NOTFOUND;
            slot_in      = '0;
            state_in     = ST_IDLE;
         end else begin
            // advance the scan: next entry read now, compared next cycle
            cmp_slot_in  = scan_addr_ff;
            scan_addr_in = advance(scan_addr_ff, cap_ff);
            remain_in    = remain_ff - cfws_pkg::CNT_W'(1);
         end
      end

      rcount_in = count_in;
      empty_in  = (count_in == '0);
      full_in   = (count_in == cap_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= cfws_pkg::CNT_W'(cfws_pkg::DEPTH);
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rd_sel_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_sel_ff    <= rd_sel_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      cmp_slot_ff  <= cmp_slot_in;
      scan_addr_ff <= scan_addr_in;
      remain_ff    <= remain_in;
      stat_ff      <= stat_in;
      slot_ff      <= slot_in;
      rcount_ff    <= rcount_in;
      empty_ff     <= empty_in;
      full_ff      <= full_in;
   end

   assign busy          = (state_ff == ST_SCAN);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = stat_ff;
   assign rsp_data      = rd_sel_ff ? ram_rdata : '0;
   assign rsp_slot      = slot_ff;
   assign rsp_count     = rcount_ff;
   assign rsp_empty_res = empty_ff;
   assign rsp_full_res  = full_ff;

   a_no_rsp_while_scan: assert property (@(posedge clock) disable iff (reset)
      busy |-> !rsp_valid)
      else $error("result strobe raised during a search scan");

   a_quick_ops_answer: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !csr_we && req_kind != cfws_pkg::OP_SEARCH) |=> rsp_valid)
      else $error("non-search command did not answer in the next cycle");

   a_count_in_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_count <= cap_ff))
      else $error("reported count exceeds capacity");

   a_slot_in_cap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == cfws_pkg::STAT_OK)
         |-> ({1'b0, rsp_slot} < cap_ff))
      else $error("reported slot outside the ring in use");

endmodule
